// ===== src/bsp_pkg.sv =====
package bsp_pkg;

    // Patch geometry
    localparam int PATCH_DIM  = 4;
    localparam int NUM_POINTS = PATCH_DIM * PATCH_DIM;
    localparam int IDX_W      = $clog2(NUM_POINTS);
    localparam int NUM_AXES   = 3;

    // Item kinds carried in tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // Operations issued to each coordinate lane
    typedef enum logic [2:0] {
        LOP_IDLE,
        LOP_CLR,
        LOP_COL,
        LOP_ROW,
        LOP_DIV,
        LOP_MUL
    } t_lane_op;

endpackage

// ===== src/bsp_ram.sv =====
module bsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bsp_weight.sv =====
module bsp_weight
    import bsp_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = 16,
    localparam int PW = PARAM_FRAC_BITS + 1,
    localparam int WW = PARAM_FRAC_BITS + 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PW-1:0]          i_u,
    input  logic [PW-1:0]          i_v,
    output logic                   o_done,
    output logic [PATCH_DIM-1:0][WW-1:0] o_wu,
    output logic [PATCH_DIM-1:0][WW-1:0] o_wv
);

    localparam int PF  = PARAM_FRAC_BITS;
    localparam int PRW = 2 * PW;
    localparam logic [PW-1:0]  SCALE    = PW'(1) << PF;
    localparam logic [PRW-1:0] HALF_ULP = PRW'(1) << (PF - 1);
    localparam logic [WW:0]    SIX_S    = (WW + 1)'(6) << PF;
    localparam logic [3:0]     STEP_MUL_END = 4'd8;
    localparam logic [3:0]     STEP_FORM    = 4'd9;

    typedef logic [PATCH_DIM-1:0][WW-1:0] t_wvec;

    // Chains: 0 = u, 1 = 1-u, 2 = v, 3 = 1-v
    logic [3:0][PW-1:0] r_p;
    logic [3:0][PW-1:0] r_sq;
    logic [3:0][PW-1:0] r_cb;
    logic [PRW-1:0]     r_prod;
    logic [2:0]         r_ptag;
    logic               r_pv;
    logic               r_busy;
    logic [3:0]         r_step;
    logic               r_done;
    t_wvec              r_wu;
    t_wvec              r_wv;

    logic [PW-1:0]  mul_a;
    logic [PW-1:0]  mul_b;
    logic [PW-1:0]  rnd;
    logic [PW-1:0]  u_cl;
    logic [PW-1:0]  v_cl;

    function automatic logic [PW-1:0] clamp_one(input logic [PW-1:0] p);
        return (p > SCALE) ? SCALE : p;
    endfunction

    // Six-times-scaled basis from t, t^2, t^3 and (1-t)^3
    function automatic t_wvec form_weights(input logic [PW-1:0] p, input logic [PW-1:0] q,
                                           input logic [PW-1:0] c, input logic [PW-1:0] ce);
        logic [WW:0] m1;
        logic [WW:0] w1;
        t_wvec       w;
        m1 = ((WW + 1)'(q) << 1) + (WW + 1)'(q) + ((WW + 1)'(p) << 1) + (WW + 1)'(p)
           + (WW + 1)'(SCALE) - ((WW + 1)'(c) << 1) - (WW + 1)'(c);
        w1 = SIX_S - (WW + 1)'(c) - m1 - (WW + 1)'(ce);
        w[0] = WW'(ce);
        w[1] = w1[WW-1:0];
        w[2] = m1[WW-1:0];
        w[3] = WW'(c);
        return w;
    endfunction

    assign u_cl  = clamp_one(i_u);
    assign v_cl  = clamp_one(i_v);
    assign mul_a = r_step[2] ? r_sq[r_step[1:0]] : r_p[r_step[1:0]];
    assign mul_b = r_p[r_step[1:0]];
    assign rnd   = PW'((r_prod + HALF_ULP) >> PF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            r_pv   <= r_busy && (r_step < STEP_MUL_END);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_p[0] <= u_cl;
                r_p[1] <= SCALE - u_cl;
                r_p[2] <= v_cl;
                r_p[3] <= SCALE - v_cl;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == STEP_FORM) begin
                    r_wu   <= form_weights(r_p[0], r_sq[0], r_cb[0], r_cb[1]);
                    r_wv   <= form_weights(r_p[2], r_sq[2], r_cb[2], r_cb[3]);
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            r_prod <= mul_a * mul_b;
            r_ptag <= r_step[2:0];
            if (r_pv) begin
                if (r_ptag[2]) begin
                    r_cb[r_ptag[1:0]] <= rnd;
                end else begin
                    r_sq[r_ptag[1:0]] <= rnd;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_wu   = r_wu;
    assign o_wv   = r_wv;

endmodule

// ===== src/bsp_lane.sv =====
module bsp_lane
    import bsp_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int WW = PARAM_FRAC_BITS + 3
) (
    input  logic                         i_clk,
    input  t_lane_op                     i_op,
    input  logic [WW-1:0]                i_weight,
    input  logic signed [COORD_BITS-1:0] i_coord,
    output logic [COORD_BITS-1:0]        o_coord
);

    localparam int CB    = COORD_BITS;
    localparam int PF    = PARAM_FRAC_BITS;
    localparam int AW    = CB + 4;
    localparam int ACC_W = CB + PF + 4;
    localparam int TOT_W = CB + PF + 8;
    localparam int YW    = CB + 4;
    localparam int RW    = CB + 5;
    localparam logic signed [ACC_W-1:0] ROW_HALF = ACC_W'(1) << (PF - 1);
    // Rounding half of 36*S plus an offset of 9*2^(CB+PF+1) that keeps the quotient positive
    localparam logic signed [TOT_W-1:0] DIV_BIAS =
        TOT_W'((64'd18 << PF) + (64'd9 << (CB + PF + 1)));
    localparam logic [RW-1:0] RECIP9 = RW'((64'd1 << (CB + 8)) / 64'd9);
    localparam logic [YW-1:0] NINE   = YW'(9);

    logic signed [ACC_W-1:0] r_rowsum;
    logic signed [TOT_W-1:0] r_total;
    logic [YW-1:0]           r_yp;
    logic [CB-1:0]           r_q0;

    logic signed [ACC_W-1:0] rs_rnd;
    logic signed [AW-1:0]    row_val;
    logic signed [AW-1:0]    mul_a;
    logic signed [WW:0]      mul_b;
    logic signed [TOT_W-1:0] prod;
    logic signed [TOT_W-1:0] bias_sum;
    logic [YW+RW-1:0]        q0_prod;
    logic [YW-1:0]           nine_q;
    logic [YW-1:0]           rem;
    logic [CB-1:0]           quo;

    assign rs_rnd   = r_rowsum + ROW_HALF;
    assign row_val  = $signed(rs_rnd[PF +: AW]);
    assign mul_a    = (i_op == LOP_ROW) ? row_val : AW'(i_coord);
    assign mul_b    = $signed({1'b0, i_weight});
    assign prod     = mul_a * mul_b;
    assign bias_sum = r_total + DIV_BIAS;
    assign q0_prod  = r_yp * RECIP9;

    // Reciprocal estimate is at most one short; fix with one compare
    assign nine_q = YW'({r_q0, 3'b000}) + YW'(r_q0);
    assign rem    = r_yp - nine_q;
    assign quo    = r_q0 + CB'(rem >= NINE);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            LOP_IDLE: begin
            end
            LOP_CLR: begin
                r_rowsum <= '0;
                r_total  <= '0;
            end
            LOP_COL: begin
                r_rowsum <= r_rowsum + prod[ACC_W-1:0];
            end
            LOP_ROW: begin
                r_total  <= r_total + prod;
                r_rowsum <= '0;
            end
            LOP_DIV: begin
                r_yp <= bias_sum[PF+2 +: YW];
            end
            LOP_MUL: begin
                r_q0 <= q0_prod[CB+8 +: CB];
            end
            default: begin
            end
        endcase
    end

    // Remove the offset: subtracting 2^(CB-1) flips the top bit
    assign o_coord = {~quo[CB-1], quo[CB-2:0]};

endmodule

// ===== src/bicubic_bspline_patch_eval.sv =====
// Channel   Dir  Handshake                     Payload (lowest bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: point_index, coord_x, coord_y, coord_z,
//                                              u_param, v_param; tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: surf_x, surf_y, surf_z
//
// A load word writes the point into the control RAM at the accepting edge. An evaluate word
// forms the basis weights on the shared weight multiplier, then makes the sixteen control RAM
// reads and four row folds, then divides by 36, rounds and loads the result register. No word
// of either kind is taken until the evaluate has loaded the result register. Synchronous
// active-low reset marks every control point as zero.
// The result register holds a word for the sink; the next word may enter meanwhile, and a
// later result waits in its last step until the register frees.
module bicubic_bspline_patch_eval
    import bsp_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int PW           = PARAM_FRAC_BITS + 1,
    localparam int IN_FIELDS_W  = IDX_W + 3 * COORD_BITS + 2 * PW,
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8,
    localparam int OUT_FIELDS_W = NUM_AXES * COORD_BITS,
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // point_index, coord_x, coord_y, coord_z, u_param, v_param, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // surf_x, surf_y, surf_z, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int WW    = PARAM_FRAC_BITS + 3;
    localparam int OFS_X = IDX_W;
    localparam int OFS_U = IDX_W + 3 * CB;
    localparam int OFS_V = OFS_U + PW;
    localparam logic [2:0] COL_FOLD = 3'd4;   // column slot that folds the row sum
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WGT,
        ST_MAC,
        ST_DIV,
        ST_MUL,
        ST_SETTLE,
        ST_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [1:0]              r_row, n_row;
    logic [2:0]              r_col, n_col;
    logic [NUM_POINTS-1:0]   r_valid, n_valid;
    logic                    r_rd_valid;
    t_lane_op                r_lop, n_lop;
    logic [WW-1:0]           r_weight, n_weight;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_FIELDS_W-1:0] r_out_data, n_out_data;

    logic                    in_acc;
    logic                    in_mode;
    logic [IDX_W-1:0]        in_idx;
    logic                    ram_we;
    logic                    ram_re;
    logic [IDX_W-1:0]        ram_raddr;
    logic [OUT_FIELDS_W-1:0] ram_rdata;
    logic                    out_free;
    logic                    w_start;
    logic                    w_done;
    logic [PATCH_DIM-1:0][WW-1:0] w_u;
    logic [PATCH_DIM-1:0][WW-1:0] w_v;
    logic [NUM_AXES-1:0][CB-1:0]  lane_out;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_mode       = s_axis_tuser;
    assign in_idx        = s_axis_tdata[IDX_W-1:0];
    assign ram_we        = in_acc && (in_mode == MODE_LOAD);
    assign w_start       = in_acc && (in_mode == MODE_EVAL);
    assign ram_re        = (r_state == ST_MAC) && (r_col != COL_FOLD);
    assign ram_raddr     = {r_row, r_col[1:0]};
    assign out_free      = !r_out_valid || m_axis_tready;

    // Control points: x, y, z side by side
    bsp_ram #(
        .WIDTH (OUT_FIELDS_W),
        .DEPTH (NUM_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_idx),
        .i_wdata (s_axis_tdata[OFS_X +: OUT_FIELDS_W]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bsp_weight #(
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_u     (s_axis_tdata[OFS_U +: PW]),
        .i_v     (s_axis_tdata[OFS_V +: PW]),
        .o_done  (w_done),
        .o_wu    (w_u),
        .o_wv    (w_v)
    );

    // One lane per axis; a slot never loaded since reset reads as the origin
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
        bsp_lane #(
            .COORD_BITS      (COORD_BITS),
            .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_op     (r_lop),
            .i_weight (r_weight),
            .i_coord  (r_rd_valid ? $signed(ram_rdata[k*CB +: CB]) : '0),
            .o_coord  (lane_out[k])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_lop       = LOP_IDLE;
        n_weight    = r_weight;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_valid     = r_valid;
        if (ram_we) begin
            n_valid[in_idx] = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_WGT;
                end
            end
            ST_WGT: begin
                // clear the lane accumulators while the weights form
                n_lop = LOP_CLR;
                if (w_done) begin
                    n_state = ST_MAC;
                    n_row   = '0;
                    n_col   = '0;
                end
            end
            ST_MAC: begin
                if (r_col != COL_FOLD) begin
                    // read issued now; lane sees the point next cycle with its column weight
                    n_lop    = LOP_COL;
                    n_weight = w_v[r_col[1:0]];
                    n_col    = r_col + 3'd1;
                end else begin
                    n_lop    = LOP_ROW;
                    n_weight = w_u[r_row];
                    n_col    = '0;
                    n_row    = r_row + 2'd1;
                    if (r_row == ROW_LAST) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_lop   = LOP_DIV;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_lop   = LOP_MUL;
                n_state = ST_SETTLE;
            end
            ST_SETTLE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold the finished point until the result register frees
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = lane_out;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_lop       <= LOP_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_lop       <= n_lop;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            r_col       <= n_col;
            r_weight    <= n_weight;
            r_out_data  <= n_out_data;
            if (ram_re) begin
                r_rd_valid <= r_valid[ram_raddr];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);

`ifndef SYNTHESIS
    a_done_in_wgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_WGT))
        else $error("weight unit finished outside the weight phase");

    a_mul_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lop == LOP_MUL) |=> (r_state == ST_DONE))
        else $error("quotient step not followed by result phase");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> m_axis_tvalid)
        else $error("finished point not presented");

    a_load_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(in_idx)])
        else $error("loaded slot not marked valid");
`endif

endmodule
